// ===== hdl/assert_macros.svh =====
// Assertion helpers for the edge block checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent implication check, reset aware.
`define ASSERT_IMPL(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// Next-cycle implication check, reset aware.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`endif

// ===== hdl/sobel_pkg.sv =====
package sobel_pkg;
  localparam int MaxWidth  = 2048;
  localparam int MaxHeight = 2048;
  localparam int ColW = $clog2(MaxWidth + 1);
  localparam int RowW = $clog2(MaxHeight + 2);
  localparam int AddrW = $clog2(MaxWidth);
  localparam int SumSat = 65025;

  localparam logic [0:0] RegWidth  = 1'b0;
  localparam logic [0:0] RegHeight = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_SHIFT, ST_GRAD, ST_SQRT, ST_OUT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture input beat, start line store read
    logic shift;  // shift window, write line stores, advance counters
    logic grad;   // form gradients for the pending result
    logic sq_init;
    logic sq_step;
    logic out_load;
    logic cfg_we;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic emit;
    logic sq_done;
  } stat_t;
endpackage

// ===== hdl/sobel_datapath.sv =====
module sobel_datapath import sobel_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  input  logic        flush,
  input  logic [0:0]  cfg_index,
  input  logic [11:0] cfg_data,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic        end_of_frame
);
  logic [11:0] width_reg, height_reg;
  logic [ColW-1:0] wc;
  logic [RowW-1:0] hc;
  logic [ColW-1:0] col;
  logic [RowW-1:0] row;
  logic [ColW-1:0] c;
  logic [RowW-1:0] r;
  logic [23:0] pix;
  logic [23:0] up_mem [MaxWidth];
  logic [23:0] mid_mem [MaxWidth];
  logic [23:0] up_rd, mid_rd;
  logic [23:0] win [3][3];
  logic [23:0] v [3][3];
  logic        emit, eof;
  logic [16:0] sum [3];
  logic [7:0]  root [3];
  logic [3:0]  bitn;

  // Clamped dimensions
  always_comb begin
    wc = (width_reg == 12'd0) ? ColW'(1) :
         ({1'b0, width_reg} > 13'(MaxWidth)) ? ColW'(MaxWidth) : ColW'(width_reg);
    hc = (height_reg == 12'd0) ? RowW'(1) :
         ({1'b0, height_reg} > 13'(MaxHeight)) ? RowW'(MaxHeight) : RowW'(height_reg);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= 12'd640;
      height_reg <= 12'd480;
    end else if (cmd.cfg_we) begin
      if (cfg_index == RegWidth) width_reg <= cfg_data;
      else height_reg <= cfg_data;
    end
  end

  // Frame-wrapped position of the current beat
  always_comb begin
    if (col >= wc || {1'b0, row} > {1'b0, hc} + 1'b1) begin
      c = '0; r = '0;
    end else begin
      c = col; r = row;
    end
  end

  // Input capture and line store read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix   <= (!flush && r < hc) ? {red_in, green_in, blue_in} : 24'd0;
      up_rd  <= up_mem[c[AddrW-1:0]];
      mid_rd <= mid_mem[c[AddrW-1:0]];
    end
  end

  // Line store write
  always_ff @(posedge clk) begin
    if (cmd.shift && c < ColW'(MaxWidth)) begin
      up_mem[c[AddrW-1:0]]  <= mid_rd;
      mid_mem[c[AddrW-1:0]] <= pix;
    end
  end

  // Row-start pending result uses the window before the shift
  logic         rs_emit;
  logic [RowW-1:0] cr;
  assign cr = r - RowW'(2);
  assign rs_emit = (c == '0) && (r >= RowW'(2)) && (cr < hc);

  // Window, counters and result selection
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0; row <= '0; emit <= 1'b0; eof <= 1'b0;
      for (int a = 0; a < 3; a++)
        for (int b = 0; b < 3; b++) win[a][b] <= '0;
    end else if (cmd.cfg_we) begin
      col <= '0; row <= '0;
    end else if (cmd.shift) begin
      logic e, f;
      logic [ColW-1:0] cn;
      e = 1'b0; f = 1'b0;
      if (rs_emit) begin
        for (int k = 0; k < 3; k++) begin
          logic rv;
          rv = (k == 1) || (k == 0 && cr >= RowW'(1)) || (k == 2 && cr + 1'b1 < hc);
          v[k][0] <= (rv && wc >= ColW'(2)) ? win[k][1] : 24'd0;
          v[k][1] <= rv ? win[k][2] : 24'd0;
          v[k][2] <= 24'd0;
        end
        e = 1'b1;
        f = (cr == hc - 1'b1);
      end
      if (c < ColW'(MaxWidth)) begin
        for (int k = 0; k < 3; k++) begin
          win[k][0] <= win[k][1];
          win[k][1] <= win[k][2];
        end
        win[0][2] <= up_rd; win[1][2] <= mid_rd; win[2][2] <= pix;
      end
      if (c >= ColW'(1) && r >= RowW'(1) && r - 1'b1 < hc) begin
        for (int k = 0; k < 3; k++) begin
          logic rv;
          rv = (k == 1) || (k == 0 && r >= RowW'(2)) || (k == 2 && r < hc);
          v[k][0] <= (rv && c >= ColW'(2)) ? win[k][1] : 24'd0;
          v[k][1] <= rv ? win[k][2] : 24'd0;
          v[k][2] <= rv ? ((k == 0) ? up_rd : (k == 1) ? mid_rd : pix) : 24'd0;
        end
        e = 1'b1;
        f = (r == hc) && (c == wc);
      end
      emit <= e; eof <= f;
      cn = c + 1'b1;
      if (f) begin
        col <= '0; row <= '0;
      end else if (cn >= wc) begin
        col <= '0; row <= r + 1'b1;
      end else begin
        col <= cn; row <= r;
      end
    end
  end

  // Gradient sums, registered per channel
  always_ff @(posedge clk) begin
    if (cmd.grad) begin
      for (int ch = 0; ch < 3; ch++) begin
        logic signed [11:0] gx, gy;
        logic [22:0] s;
        gx = 12'(v[0][2][ch*8 +: 8]) + 12'(v[1][2][ch*8 +: 8]) * 12'sd2
           + 12'(v[2][2][ch*8 +: 8]) - 12'(v[0][0][ch*8 +: 8])
           - 12'(v[1][0][ch*8 +: 8]) * 12'sd2 - 12'(v[2][0][ch*8 +: 8]);
        gy = 12'(v[2][0][ch*8 +: 8]) + 12'(v[2][1][ch*8 +: 8]) * 12'sd2
           + 12'(v[2][2][ch*8 +: 8]) - 12'(v[0][0][ch*8 +: 8])
           - 12'(v[0][1][ch*8 +: 8]) * 12'sd2 - 12'(v[0][2][ch*8 +: 8]);
        s = 23'(gx * gx) + 23'(gy * gy);
        sum[ch] <= (s > 23'(SumSat)) ? 17'h1ffff : s[16:0];
      end
    end
  end

  // Bit-serial square root, one result bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.sq_init) begin
      bitn <= 4'd7;
      for (int ch = 0; ch < 3; ch++) root[ch] <= '0;
    end else if (cmd.sq_step) begin
      for (int ch = 0; ch < 3; ch++) begin
        logic [7:0] t;
        t = root[ch] | (8'd1 << bitn[2:0]);
        if (sum[ch] == 17'h1ffff) root[ch] <= 8'd255;
        else if (17'(16'(t) * 16'(t)) <= sum[ch]) root[ch] <= t;
      end
      bitn <= bitn - 1'b1;
    end
  end
  assign stat = '{emit: emit, sq_done: (bitn == 4'd0)};

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      red_out <= root[2]; green_out <= root[1]; blue_out <= root[0];
      end_of_frame <= eof;
    end
  end
endmodule

// ===== hdl/sobel_ctrl.sv =====
module sobel_ctrl import sobel_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  logic  out_room,
  input  logic  cfg_valid,
  output logic  cfg_ready,
  input  stat_t stat,
  output cmd_t  cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Sequencer: read, shift, gradients, 8 root steps, present
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    cfg_ready = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        in_ready = !cfg_valid;
        if (cfg_valid) cmd.cfg_we = 1'b1;
        else if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.shift = 1'b1;
        state_next = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (stat.emit) begin
          cmd.grad = 1'b1;
          state_next = ST_GRAD;
        end else state_next = ST_IDLE;
      end
      ST_GRAD: begin
        cmd.sq_init = 1'b1;
        state_next = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sq_step = 1'b1;
        if (stat.sq_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        // wait here until the output register can take the beat
        if (out_room) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// ===== hdl/sobel_edge_magnitude_rgb.sv =====
// Sobel edge magnitude over a raster stream of 24-bit RGB pixels.
// Input channel: in_valid/in_ready with red_in, green_in, blue_in, flush.
// Output channel: out_valid/out_ready with red_out, green_out, blue_out,
// end_of_frame. Config channel: cfg_valid/cfg_ready, cfg_index, cfg_data
// (0 = image width, 1 = image height); a write restarts the frame.
// A beat that yields a result passes, before the next beat is accepted,
// through capture and line store read, window shift, gradient sums,
// square root setup, an 8-step bit-serial square root shared by the
// three channels, then the output register load.
// A beat with no result returns to idle after the window shift.
// A result belongs to the pixel one row plus one pixel earlier; send
// width+1 flush beats after each frame to drain it.
// The output register holds its beat while out_ready is low; the next
// input beat is taken meanwhile, and the sequencer waits in its last state
// until the output register is empty or being read.
// Reset (synchronous, rst high) restores 640x480 and clears the window
// and counters; line store contents are masked at frame edges.
module sobel_edge_magnitude_rgb import sobel_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  input  logic        flush,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic        end_of_frame,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  cmd_t  cmd;
  stat_t stat;
  logic  in_ready_c, cfg_ready_c;
  logic  full;

  // New beats start while the output holds; final load and config wait.
  sobel_ctrl u_ctrl (
    .clk, .rst, .in_valid(in_valid && !cfg_valid), .in_ready(in_ready_c),
    .out_room(!full || out_ready), .cfg_valid(cfg_valid && !full),
    .cfg_ready(cfg_ready_c), .stat, .cmd
  );

  assign in_ready  = in_ready_c && !cfg_valid;
  assign cfg_ready = cfg_ready_c && !full;

  sobel_datapath u_dp (
    .clk, .rst, .cmd, .stat, .red_in, .green_in, .blue_in, .flush,
    .cfg_index, .cfg_data, .red_out, .green_out, .blue_out, .end_of_frame
  );

  // Output valid flag
  always_ff @(posedge clk) begin
    if (rst) full <= 1'b0;
    else if (cmd.out_load) full <= 1'b1;
    else if (out_ready) full <= 1'b0;
  end
  assign out_valid = full;
endmodule

// ===== hdl/sobel_checker.sv =====
`include "assert_macros.svh"
module sobel_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic end_of_frame,
  input logic cfg_valid,
  input logic cfg_ready
);
  `ASSERT_NEXT(p_out_hold, clk, rst, out_valid && !out_ready, out_valid, "output beat dropped")
  `ASSERT_IMPL(p_no_cfg_in, clk, rst, cfg_valid && cfg_ready, !in_ready, "cfg and input together")
  `ASSERT_NEXT(p_eof_hold, clk, rst, out_valid && !out_ready, $stable(end_of_frame), "eof changed")
  `ASSERT_NEXT(p_in_gap, clk, rst, in_valid && in_ready, !in_ready, "input taken twice in a row")
endmodule

bind sobel_edge_magnitude_rgb sobel_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .end_of_frame,
  .cfg_valid, .cfg_ready
);
